### hdl/shs_pkg.sv
// Package for the SHA-256 stream hasher: word and block types, controller
// states, round constants, initial chain value and the SHA-256 mixing functions.
// No dependencies.
package shs_pkg;

  typedef logic [31:0] word_t;
  typedef word_t [15:0] block_t;
  typedef word_t [7:0]  chain_t;

  typedef enum logic [1:0] {
    StIdle,
    StPad,
    StComp,
    StOut
  } state_e;

  localparam logic [7:0] PadMarker = 8'h80;
  localparam logic [5:0] LenOffset = 6'd56;

  // index 0 is H0
  localparam chain_t InitChain = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  localparam word_t RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic word_t rotr(word_t x, int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t big_sig0(word_t x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t big_sig1(word_t x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic word_t small_sig0(word_t x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t small_sig1(word_t x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic word_t ch(word_t e, word_t f, word_t g);
    return (e & f) ^ (~e & g);
  endfunction

  function automatic word_t maj(word_t a, word_t b, word_t c);
    return (a & b) ^ (a & c) ^ (b & c);
  endfunction

endpackage

### hdl/shs_compress.sv
// SHA-256 block compression, one round per cycle over a 16-word schedule window.
// Depends on shs_pkg.
module shs_compress (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  shs_pkg::block_t block_i,
  input  shs_pkg::chain_t chain_i,
  output logic            done_o,
  output shs_pkg::chain_t chain_o
);

  logic              busy_q, busy_d;
  logic              fin_q, fin_d;
  logic [5:0]        rnd_q, rnd_d;
  shs_pkg::chain_t   v_q, v_d;
  shs_pkg::block_t   w_q, w_d;
  shs_pkg::word_t    t1, t2, w_new;

  always_comb begin
    t1 = v_q[7] + shs_pkg::big_sig1(v_q[4]) + shs_pkg::ch(v_q[4], v_q[5], v_q[6])
         + shs_pkg::RoundK[rnd_q] + w_q[0];
    t2 = shs_pkg::big_sig0(v_q[0]) + shs_pkg::maj(v_q[0], v_q[1], v_q[2]);
    w_new = w_q[0] + shs_pkg::small_sig0(w_q[1]) + w_q[9] + shs_pkg::small_sig1(w_q[14]);
  end

  always_comb begin
    busy_d = busy_q;
    fin_d  = 1'b0;
    rnd_d  = rnd_q;
    v_d    = v_q;
    w_d    = w_q;
    if (start_i && !busy_q) begin
      busy_d = 1'b1;
      rnd_d  = '0;
      v_d    = chain_i;
      w_d    = block_i;
    end else if (busy_q) begin
      v_d[7] = v_q[6];
      v_d[6] = v_q[5];
      v_d[5] = v_q[4];
      v_d[4] = v_q[3] + t1;
      v_d[3] = v_q[2];
      v_d[2] = v_q[1];
      v_d[1] = v_q[0];
      v_d[0] = t1 + t2;
      for (int i = 0; i < 15; i++) begin
        w_d[i] = w_q[i+1];
      end
      w_d[15] = w_new;
      rnd_d   = rnd_q + 6'd1;
      if (&rnd_q) begin
        busy_d = 1'b0;
        fin_d  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      rnd_q  <= '0;
    end else begin
      busy_q <= busy_d;
      fin_q  <= fin_d;
      rnd_q  <= rnd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q <= v_d;
    w_q <= w_d;
  end

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      chain_o[i] = chain_i[i] + v_q[i];
    end
  end

  assign done_o = fin_q;

endmodule

### hdl/sha256_stream_hasher.sv
// SHA-256 stream hasher: one byte per cycle into the block buffer while idle; each full
// block stalls input while it is compressed (launch, 64 rounds, then fold).
// A final byte adds padding at one byte a cycle (9 to 72 bytes) with its
// compressions, then four digest transactions, one a cycle when taken.
// Reset (async, active low) loads the initial chain value and clears counters.
// Depends on shs_pkg and shs_compress.
module sha256_stream_hasher (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_message_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] digest_word_o,
  output logic [1:0]  word_number_o,
  output logic        digest_done_o
);

  shs_pkg::state_e state_q, state_d;
  shs_pkg::chain_t chain_q, chain_d, chain_sum;
  shs_pkg::block_t blk_q;
  logic [63:0]     msg_q, msg_d, bit_len;
  logic [5:0]      fill_q, fill_d;
  logic [2:0]      len_cnt_q, len_cnt_d;
  logic [1:0]      word_q, word_d;
  logic            pad_q, pad_d, sent80_q, sent80_d, final_q, final_d, start_q;
  logic            push_en, full, len_act, in_acc, out_last, cmp_done;
  logic [7:0]      push_byte, len_byte;

  shs_compress u_compress (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_q),
    .block_i (blk_q),
    .chain_i (chain_q),
    .done_o  (cmp_done),
    .chain_o (chain_sum)
  );

  assign bit_len  = {msg_q[60:0], 3'b000};
  assign len_byte = bit_len[{~len_cnt_q, 3'b000} +: 8];
  assign len_act  = sent80_q && ((fill_q == shs_pkg::LenOffset) || (len_cnt_q != 3'd0));
  assign in_acc   = in_valid_i && in_ready_o;
  assign out_last = out_valid_o && out_ready_i && (&word_q);
  assign full     = push_en && (&fill_q);

  // outputs and padding byte select
  always_comb begin
    in_ready_o  = (state_q == shs_pkg::StIdle);
    out_valid_o = (state_q == shs_pkg::StOut);
    push_en     = 1'b0;
    push_byte   = data_byte_i;
    unique case (state_q)
      shs_pkg::StIdle: push_en = in_valid_i;
      shs_pkg::StPad: begin
        push_en = 1'b1;
        if (!sent80_q) begin
          push_byte = shs_pkg::PadMarker;
        end else if (len_act) begin
          push_byte = len_byte;
        end else begin
          push_byte = 8'h00;
        end
      end
      default: push_en = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      shs_pkg::StIdle: begin
        if (in_valid_i) begin
          if (full) begin
            state_d = shs_pkg::StComp;
          end else if (end_of_message_i) begin
            state_d = shs_pkg::StPad;
          end
        end
      end
      shs_pkg::StPad: begin
        if (full) begin
          state_d = shs_pkg::StComp;
        end
      end
      shs_pkg::StComp: begin
        if (cmp_done) begin
          priority if (final_q) begin
            state_d = shs_pkg::StOut;
          end else if (pad_q) begin
            state_d = shs_pkg::StPad;
          end else begin
            state_d = shs_pkg::StIdle;
          end
        end
      end
      shs_pkg::StOut: begin
        if (out_last) begin
          state_d = shs_pkg::StIdle;
        end
      end
      default: state_d = shs_pkg::StIdle;
    endcase
  end

  // datapath state
  always_comb begin
    chain_d   = chain_q;
    msg_d     = msg_q;
    fill_d    = fill_q;
    len_cnt_d = len_cnt_q;
    word_d    = word_q;
    pad_d     = pad_q;
    sent80_d  = sent80_q;
    final_d   = final_q;
    if (in_acc) begin
      msg_d = msg_q + 64'd1;
      if (end_of_message_i) begin
        pad_d = 1'b1;
      end
    end
    if (push_en) begin
      fill_d = full ? 6'd0 : fill_q + 6'd1;
      if (state_q == shs_pkg::StPad) begin
        if (!sent80_q) begin
          sent80_d = 1'b1;
        end else if (len_act) begin
          len_cnt_d = len_cnt_q + 3'd1;
          if (&len_cnt_q) begin
            final_d = 1'b1;
          end
        end
      end
    end
    if (cmp_done) begin
      chain_d = chain_sum;
    end
    if (out_valid_o && out_ready_i) begin
      word_d = word_q + 2'd1;
    end
    if (out_last) begin
      chain_d   = shs_pkg::InitChain;
      msg_d     = '0;
      fill_d    = '0;
      len_cnt_d = '0;
      pad_d     = 1'b0;
      sent80_d  = 1'b0;
      final_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= shs_pkg::StIdle;
      chain_q   <= shs_pkg::InitChain;
      msg_q     <= '0;
      fill_q    <= '0;
      len_cnt_q <= '0;
      word_q    <= '0;
      pad_q     <= 1'b0;
      sent80_q  <= 1'b0;
      final_q   <= 1'b0;
      start_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      chain_q   <= chain_d;
      msg_q     <= msg_d;
      fill_q    <= fill_d;
      len_cnt_q <= len_cnt_d;
      word_q    <= word_d;
      pad_q     <= pad_d;
      sent80_q  <= sent80_d;
      final_q   <= final_d;
      start_q   <= full;
    end
  end

  // big-endian byte lanes
  always_ff @(posedge clk_i) begin
    if (push_en) begin
      blk_q[fill_q[5:2]][{~fill_q[1:0], 3'b000} +: 8] <= push_byte;
    end
  end

  assign digest_word_o = {chain_q[{word_q, 1'b0}], chain_q[{word_q, 1'b1}]};
  assign word_number_o = word_q;
  assign digest_done_o = &word_q;

endmodule
